// ===== src/qtf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtf_pkg
// Shared widths, register indexes and types of the quadrupole trap force block.
// ----------------------------------------------------------------------------
package qtf_pkg;

    localparam int POS_W     = 32;
    localparam int GAIN_W    = 32;
    localparam int PHASE_W   = 32;
    localparam int FORCE_W   = 48;
    localparam int COS_W     = 17;   // signed Q1.15 cosine, +/-32767
    localparam int RFP_W     = GAIN_W + COS_W;
    localparam int GX_W      = 34;   // gain sums and differences
    localparam int PROD_W    = GX_W + POS_W;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 32;
    localparam int STAGES    = 8;
    localparam int COS_STG   = 4;
    localparam int FRC_STG   = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_RF_GAIN      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DC_GAIN      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_OFFSET = 2'd3;

    typedef struct packed {
        logic signed [GAIN_W-1:0] rf_gain;
        logic signed [GAIN_W-1:0] dc_gain;
        logic [PHASE_W-1:0]       phase_step;
        logic [PHASE_W-1:0]       phase_offset;
    } t_cfg;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
    } t_pos;

    typedef logic [COS_STG-1:0] t_cos_en;
    typedef logic [FRC_STG-1:0] t_frc_en;

endpackage

// ===== src/qtf_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtf_in_if
// Input word channel: ion position and time, valid/ready handshake.
// ----------------------------------------------------------------------------
interface qtf_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [qtf_pkg::POS_W-1:0]     pos_x;
    logic signed [qtf_pkg::POS_W-1:0]     pos_y;
    logic signed [qtf_pkg::POS_W-1:0]     pos_z;
    logic [qtf_pkg::PHASE_W-1:0]          time_ticks;

    modport source (output valid, output pos_x, output pos_y, output pos_z,
                    output time_ticks, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                    input time_ticks, output ready);
endinterface

// ===== src/qtf_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtf_out_if
// Output word channel: force vector, valid/ready handshake.
// ----------------------------------------------------------------------------
interface qtf_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [qtf_pkg::FORCE_W-1:0]   force_x;
    logic signed [qtf_pkg::FORCE_W-1:0]   force_y;
    logic signed [qtf_pkg::FORCE_W-1:0]   force_z;

    modport source (output valid, output force_x, output force_y, output force_z,
                    input ready);
    modport sink   (input valid, input force_x, input force_y, input force_z,
                    output ready);
endinterface

// ===== src/qtf_cos.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtf_cos
// Four-stage rf phase and cosine path: phase product, offset add,
// quadrant fold to a table address, quarter-wave table read and quadrant sign.
// ----------------------------------------------------------------------------
module qtf_cos #(
    parameter int COS_TABLE_DEPTH = 256
) (
    input  logic                                i_clk,
    input  qtf_pkg::t_cos_en                    i_en,
    input  logic [qtf_pkg::PHASE_W-1:0]         i_time,
    input  logic [qtf_pkg::PHASE_W-1:0]         i_step,
    input  logic [qtf_pkg::PHASE_W-1:0]         i_offset,
    output logic signed [qtf_pkg::COS_W-1:0]    o_cos
);

    localparam int    IdxW      = $clog2(COS_TABLE_DEPTH + 1);
    localparam int    FracW     = 30;
    localparam int    MulW      = FracW + IdxW;
    localparam longint DepthL   = COS_TABLE_DEPTH;
    localparam longint OneQ30   = 64'sd1 << 30;
    localparam longint HalfPi   = 64'sd1686629713;
    localparam longint Den [1:10] = '{64'sd2, 64'sd12, 64'sd30, 64'sd56, 64'sd90,
                                      64'sd132, 64'sd182, 64'sd240, 64'sd306, 64'sd380};

    // Taylor series of cos in Q2.30, Horner form, then rounded to Q1.15
    function automatic logic [14:0] rom_entry(input int idx);
        longint a;
        longint a2;
        longint r;
        longint t;
        a  = (HalfPi * longint'(idx)) / DepthL;
        a2 = (a * a) / OneQ30;
        r  = OneQ30;
        for (int k = 10; k >= 1; k--) begin
            r = OneQ30 - ((a2 * r) / OneQ30) / Den[k];
        end
        if (r < 0) begin
            t = 0;
        end else begin
            t = (r + (64'sd1 << 14)) >>> 15;
            if (t > 32767) begin
                t = 32767;
            end
        end
        return t[14:0];
    endfunction

    logic [14:0] w_rom [0:COS_TABLE_DEPTH];

    for (genvar g = 0; g <= COS_TABLE_DEPTH; g++) begin : g_rom
        localparam logic [14:0] Entry = rom_entry(g);
        assign w_rom[g] = Entry;
    end

    logic [qtf_pkg::PHASE_W-1:0] r_s1_mul;
    logic [qtf_pkg::PHASE_W-1:0] r_s2_phase;
    logic [IdxW-1:0]             r_s3_addr;
    logic                        r_s3_neg;

    logic [MulW-1:0]  w_idx_prod;
    logic [IdxW-1:0]  w_idx;
    logic [1:0]       w_quad;
    logic [IdxW-1:0]  n_s3_addr;
    logic signed [qtf_pkg::COS_W-1:0] w_mag;

    always_comb begin
        w_quad     = r_s2_phase[31:30];
        w_idx_prod = {{IdxW{1'b0}}, r_s2_phase[FracW-1:0]} * MulW'(COS_TABLE_DEPTH);
        w_idx      = w_idx_prod[FracW +: IdxW];
        // odd quadrants read the table backward
        n_s3_addr  = w_quad[0] ? (IdxW'(COS_TABLE_DEPTH) - w_idx) : w_idx;
        w_mag      = {2'b00, w_rom[r_s3_addr]};
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_s1_mul <= qtf_pkg::PHASE_W'(i_step * i_time);
        end
        if (i_en[1]) begin
            r_s2_phase <= r_s1_mul + i_offset;
        end
        if (i_en[2]) begin
            r_s3_addr <= n_s3_addr;
            r_s3_neg  <= w_quad[1] ^ w_quad[0];
        end
        if (i_en[3]) begin
            o_cos <= r_s3_neg ? -w_mag : w_mag;
        end
    end

endmodule

// ===== src/qtf_force.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtf_force
// Four-stage force path: rf term product, gain combine, position
// products, floor shift and 48-bit saturation.
// ----------------------------------------------------------------------------
module qtf_force (
    input  logic                                 i_clk,
    input  qtf_pkg::t_frc_en                     i_en,
    input  logic signed [qtf_pkg::GAIN_W-1:0]    i_rf_gain,
    input  logic signed [qtf_pkg::GAIN_W-1:0]    i_dc_gain,
    input  logic signed [qtf_pkg::COS_W-1:0]     i_cos,
    input  qtf_pkg::t_pos                        i_pos,
    output logic signed [qtf_pkg::FORCE_W-1:0]   o_force_x,
    output logic signed [qtf_pkg::FORCE_W-1:0]   o_force_y,
    output logic signed [qtf_pkg::FORCE_W-1:0]   o_force_z
);

    localparam int ShW = qtf_pkg::PROD_W - 16;

    function automatic logic signed [qtf_pkg::FORCE_W-1:0] sat_shift(
        input logic signed [qtf_pkg::PROD_W-1:0] p
    );
        logic signed [ShW-1:0] s;
        logic [2:0]            top;
        s   = p[qtf_pkg::PROD_W-1:16];
        top = s[ShW-1:qtf_pkg::FORCE_W-1];
        if (top == 3'b000 || top == 3'b111) begin
            return s[qtf_pkg::FORCE_W-1:0];
        end else if (s[ShW-1]) begin
            return {1'b1, {(qtf_pkg::FORCE_W-1){1'b0}}};
        end else begin
            return {1'b0, {(qtf_pkg::FORCE_W-1){1'b1}}};
        end
    endfunction

    logic signed [qtf_pkg::RFP_W-1:0]  r_s5_rfp;
    logic signed [qtf_pkg::GX_W-1:0]   r_s6_ga;
    logic signed [qtf_pkg::GX_W-1:0]   r_s6_gb;
    logic signed [qtf_pkg::GX_W-1:0]   r_s6_gz;
    logic signed [qtf_pkg::PROD_W-1:0] r_s7_px;
    logic signed [qtf_pkg::PROD_W-1:0] r_s7_py;
    logic signed [qtf_pkg::PROD_W-1:0] r_s7_pz;

    logic signed [qtf_pkg::RFP_W-1:0]  w_rfp;
    logic signed [qtf_pkg::GX_W-1:0]   w_rf;
    logic signed [qtf_pkg::GX_W-1:0]   w_dc;
    logic signed [qtf_pkg::PROD_W-1:0] w_px;
    logic signed [qtf_pkg::PROD_W-1:0] w_py;
    logic signed [qtf_pkg::PROD_W-1:0] w_pz;

    always_comb begin
        w_rfp = i_rf_gain * i_cos;
        // floor shift by 15; the result stays within 33 bits
        w_rf  = r_s5_rfp[qtf_pkg::RFP_W-1:15];
        w_dc  = qtf_pkg::GX_W'(i_dc_gain);
        w_px  = r_s6_ga * i_pos.x;
        w_py  = r_s6_gb * i_pos.y;
        w_pz  = r_s6_gz * i_pos.z;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_s5_rfp <= w_rfp;
        end
        if (i_en[1]) begin
            r_s6_ga <= w_dc - w_rf;
            r_s6_gb <= w_rf + w_dc;
            r_s6_gz <= -(w_dc <<< 1);
        end
        if (i_en[2]) begin
            r_s7_px <= w_px;
            r_s7_py <= w_py;
            r_s7_pz <= w_pz;
        end
        if (i_en[3]) begin
            o_force_x <= sat_shift(r_s7_px);
            o_force_y <= sat_shift(r_s7_py);
            o_force_z <= sat_shift(r_s7_pz);
        end
    end

endmodule

// ===== src/quadrupole_trap_force_top.sv =====
`timescale 1ns / 1ps
// An accepted input word passes through the stage registers to its force word on o_out.
// Throughput: one word per cycle; every stage is a plain register stage, so a
//   new position can enter each cycle while the output side keeps pace.
// Reset: synchronous, active low; clears all stage valid bits and the four
//   configuration registers to zero. Payload registers are not reset.
// ----------------------------------------------------------------------------
// quadrupole_trap_force_top
// Force on a singly charged ion in a linear quadrupole trap with a DC end-cap
// potential, from ion position and time, against an rf cosine drive.
// ----------------------------------------------------------------------------
module quadrupole_trap_force_top #(
    parameter int COS_TABLE_DEPTH = 256
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    qtf_in_if.sink                                i_in,
    qtf_out_if.source                             o_out,
    input  logic                                  i_cfg_we,
    input  logic [qtf_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [qtf_pkg::CFG_W-1:0]             i_cfg_data
);

    // Stage map
    //   1  phase_step * time_ticks (low 32 bits)
    //   2  add phase_offset -> 32-bit phase, a fraction of a turn
    //   3  scale phase to a table index, fold the quadrant to an address
    //   4  quarter-wave table read, apply the quadrant sign
    //   5  rf_gain * cosine
    //   6  floor shift by 15, form dc-rf, rf+dc and -2*dc
    //   7  gain times position, three multipliers
    //   8  floor shift by 16, saturate to 48 bits -> output register
    localparam int NStg = qtf_pkg::STAGES;
    localparam int PosStg = 6;   // positions ride along until the stage 7 multiply

    qtf_pkg::t_cfg r_cfg;
    logic [NStg-1:0] r_vld;
    logic [NStg-1:0] w_en;
    qtf_pkg::t_pos r_pos [0:PosStg-1];
    qtf_pkg::t_pos w_pos_in;
    logic signed [qtf_pkg::COS_W-1:0] w_cos;

    // Configuration writes; an index past the list is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                qtf_pkg::CFG_RF_GAIN:      r_cfg.rf_gain      <= i_cfg_data;
                qtf_pkg::CFG_DC_GAIN:      r_cfg.dc_gain      <= i_cfg_data;
                qtf_pkg::CFG_PHASE_STEP:   r_cfg.phase_step   <= i_cfg_data;
                qtf_pkg::CFG_PHASE_OFFSET: r_cfg.phase_offset <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // A stage loads when it is empty or its content moves on this cycle;
    // bubbles collapse, a full stalled stage holds.
    always_comb begin
        w_en[NStg-1] = !r_vld[NStg-1] || o_out.ready;
        for (int k = NStg - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign i_in.ready  = w_en[0];
    assign o_out.valid = r_vld[NStg-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_in.valid;
            end
            for (int k = 1; k < NStg; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Position delay line, advanced with stages 1..6
    always_comb begin
        w_pos_in.x = i_in.pos_x;
        w_pos_in.y = i_in.pos_y;
        w_pos_in.z = i_in.pos_z;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_pos[0] <= w_pos_in;
        end
        for (int k = 1; k < PosStg; k++) begin
            if (w_en[k]) begin
                r_pos[k] <= r_pos[k-1];
            end
        end
    end

    qtf_cos #(
        .COS_TABLE_DEPTH (COS_TABLE_DEPTH)
    ) u_cos (
        .i_clk    (i_clk),
        .i_en     (w_en[qtf_pkg::COS_STG-1:0]),
        .i_time   (i_in.time_ticks),
        .i_step   (r_cfg.phase_step),
        .i_offset (r_cfg.phase_offset),
        .o_cos    (w_cos)
    );

    qtf_force u_force (
        .i_clk     (i_clk),
        .i_en      (w_en[NStg-1:qtf_pkg::COS_STG]),
        .i_rf_gain (r_cfg.rf_gain),
        .i_dc_gain (r_cfg.dc_gain),
        .i_cos     (w_cos),
        .i_pos     (r_pos[PosStg-1]),
        .o_force_x (o_out.force_x),
        .o_force_y (o_out.force_y),
        .o_force_z (o_out.force_z)
    );

endmodule
